// ===== design/ccpl_pkg.sv =====
// Shared constants for the capped characteristic path length block.
// Holds the fixed port field widths and parameter defaults.
// No dependencies.
package ccpl_pkg;

    localparam int DEF_MAX_NODES   = 32;
    localparam int DEF_LENGTH_BITS = 16;

    // Fixed field widths of the ports.
    localparam int CFG_W   = 6;
    localparam int IN_W    = 16;
    localparam int MEAN_W  = 21;
    localparam int TDATA_W = 24;

    // Node count register value after reset.
    localparam int RESET_NODES = 32;

endpackage

// ===== design/capped_char_path_length.sv =====
// Capped characteristic path length: top level with its store, solver sequencer and divider.
// Depends on ccpl_pkg for field widths and parameter defaults.
//
// Loads an N-by-N matrix of Q8.8 connection lengths in row-major order, one item per cycle
// while s_tready is high (zero means no edge; diagonal items are ignored). After the last
// item the block computes all-pairs shortest paths with one shared add-and-compare unit over a
// two-read-port store, caps each off-diagonal distance at N times the mean nonzero length, and
// returns the truncated mean of the capped distances. One result item follows every N*N input
// items; if no off-diagonal length was nonzero the result is 0 with the no_edges flag set, with
// no solve. The solve runs a shortest-path sweep (one relaxation per cycle along each row), a
// capping sweep and two bit-serial divisions; s_tready stays low meanwhile. A node_count write
// (taken only while loading) discards a partial matrix and restarts with the new N.
module capped_char_path_length #(
    parameter int MAX_NODES   = ccpl_pkg::DEF_MAX_NODES,
    parameter int LENGTH_BITS = ccpl_pkg::DEF_LENGTH_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration: node_count.
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ccpl_pkg::CFG_W-1:0]   cfg_data,
    // Input items.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ccpl_pkg::IN_W-1:0]    s_tdata,   // [15:0] edge_length
    // Result items.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ccpl_pkg::TDATA_W-1:0] m_tdata,   // [20:0] capped_mean, rest zero
    output logic                         m_tuser    // [0] no_edges
);

    localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NCW   = $clog2(MAX_NODES + 1);
    localparam int EL    = (LENGTH_BITS < ccpl_pkg::IN_W) ? LENGTH_BITS : ccpl_pkg::IN_W;
    localparam int AW    = 2 * NW;
    localparam int DEPTH = 1 << AW;
    localparam int DW    = EL + NW;
    localparam int SUMW  = EL + 2 * NW;
    localparam int CNTW  = 2 * NW;
    localparam int DMW   = EL + NCW;
    localparam int CSW   = DMW + 2 * NW;
    localparam int DVD_W = CSW;
    localparam int DVS_W = 2 * NW;
    localparam int DCW   = $clog2(DVD_W);
    localparam int XW    = (CSW > ccpl_pkg::MEAN_W) ? CSW : ccpl_pkg::MEAN_W;
    localparam int CMPW  = (NCW > ccpl_pkg::CFG_W) ? NCW : ccpl_pkg::CFG_W;
    localparam int RST_N = (ccpl_pkg::RESET_NODES > MAX_NODES) ? MAX_NODES
                                                                : ccpl_pkg::RESET_NODES;

    typedef enum logic [12:0] {
        ST_LOAD      = 13'b0000000000001,
        ST_DIVA_GO   = 13'b0000000000010,
        ST_DIVA      = 13'b0000000000100,
        ST_SCALE     = 13'b0000000001000,
        ST_HEAD      = 13'b0000000010000,
        ST_LATCH     = 13'b0000000100000,
        ST_ROW       = 13'b0000001000000,
        ST_DRAIN     = 13'b0000010000000,
        ST_CAP       = 13'b0000100000000,
        ST_CAP_DRAIN = 13'b0001000000000,
        ST_DIVB_GO   = 13'b0010000000000,
        ST_DIVB      = 13'b0100000000000,
        ST_OUT       = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [NCW-1:0]   n_reg, n_next;
    logic [NW-1:0]    nl_reg, nl_next;
    logic [NW-1:0]    row_reg, row_next, col_reg, col_next;
    logic [SUMW-1:0]  sum_reg, sum_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic [CSW-1:0]   csum_reg, csum_next;
    logic [NW-1:0]    k_reg, k_next, i_reg, i_next, j_reg, j_next;
    logic             fw_pv_reg, fw_pv_next, cap_pv_reg, cap_pv_next;
    logic [NW-1:0]    pj_reg, pj_next;
    logic             pdiag_reg, pdiag_next;
    logic [DW-1:0]    dik_reg, dik_next;
    logic [DMW-1:0]   dmax_reg, dmax_next;
    logic [DVS_W:0]   dv_rem_reg, dv_rem_next;
    logic [DVD_W-1:0] dv_quo_reg, dv_quo_next;
    logic [DVS_W-1:0] dv_den_reg, dv_den_next;
    logic [DCW-1:0]   dv_cnt_reg, dv_cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic [ccpl_pkg::MEAN_W-1:0] m_mean_reg, m_mean_next;
    logic             m_noedge_reg, m_noedge_next;

    // Distance store: loaded lengths, then distances. Zero off the diagonal means unreachable.
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_a_reg, rd_b_reg;
    logic [AW-1:0] ra, rb, wa;
    logic [DW-1:0] wd;
    logic          we;

    logic [CMPW-1:0] cfg_x;
    logic [NCW-1:0]  n_clamp;
    logic [EL-1:0]   len;
    logic            offdiag_in, nz_hit, last_pos, s_accept;
    logic            reach_kj, reach_ij, fw_upd;
    logic [DW:0]     via;
    logic [DMW-1:0]  cap_d, cap_term;
    logic [DVS_W:0]  dv_sh;
    logic            dv_ge;
    logic [XW-1:0]   quo_x;

    assign cfg_x   = CMPW'(cfg_data);
    assign n_clamp = (cfg_x < CMPW'(2)) ? NCW'(2)
                   : (cfg_x > CMPW'(MAX_NODES)) ? NCW'(MAX_NODES) : NCW'(cfg_x);

    assign len        = s_tdata[EL-1:0];
    assign offdiag_in = (row_reg != col_reg);
    assign nz_hit     = offdiag_in && (len != '0);
    assign last_pos   = (row_reg == nl_reg) && (col_reg == nl_reg);

    // A configuration write takes precedence over an input item in the same cycle.
    assign cfg_ready = (state_reg == ST_LOAD);
    assign s_tready  = (state_reg == ST_LOAD) && !cfg_valid && !(last_pos && m_valid_reg);
    assign s_accept  = s_tvalid && s_tready;

    // Relaxation unit: rd_a holds d[k][j], rd_b holds d[i][j] for column pj.
    assign reach_kj = (k_reg == pj_reg) || (rd_a_reg != '0);
    assign reach_ij = (i_reg == pj_reg) || (rd_b_reg != '0);
    assign via      = {1'b0, dik_reg} + {1'b0, rd_a_reg};
    assign fw_upd   = fw_pv_reg && reach_kj && (!reach_ij || (via < {1'b0, rd_b_reg}));

    // Capping unit.
    assign cap_d    = DMW'(rd_a_reg);
    assign cap_term = ((rd_a_reg == '0) || (cap_d >= dmax_reg)) ? dmax_reg : cap_d;

    // Restoring divider step, one quotient bit per cycle.
    assign dv_sh = {dv_rem_reg[DVS_W-1:0], dv_quo_reg[DVD_W-1]};
    assign dv_ge = (dv_sh >= {1'b0, dv_den_reg});
    assign quo_x = XW'(dv_quo_reg);

    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        nl_next       = nl_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        csum_next     = csum_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        fw_pv_next    = 1'b0;
        cap_pv_next   = 1'b0;
        pj_next       = pj_reg;
        pdiag_next    = pdiag_reg;
        dik_next      = dik_reg;
        dmax_next     = dmax_reg;
        dv_rem_next   = dv_rem_reg;
        dv_quo_next   = dv_quo_reg;
        dv_den_next   = dv_den_reg;
        dv_cnt_next   = dv_cnt_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_mean_next   = m_mean_reg;
        m_noedge_next = m_noedge_reg;
        we = 1'b0;
        wa = '0;
        wd = '0;
        ra = '0;
        rb = '0;

        if (fw_upd) begin
            we = 1'b1;
            wa = {i_reg, pj_reg};
            wd = via[DW-1:0];
        end
        if (cap_pv_reg && !pdiag_reg) begin
            csum_next = csum_reg + CSW'(cap_term);
        end

        case (state_reg)
            ST_LOAD: begin
                if (cfg_valid) begin
                    n_next    = n_clamp;
                    nl_next   = NW'(n_clamp - NCW'(1));
                    row_next  = '0;
                    col_next  = '0;
                    sum_next  = '0;
                    cnt_next  = '0;
                    csum_next = '0;
                end else if (s_accept) begin
                    we = 1'b1;
                    wa = {row_reg, col_reg};
                    wd = offdiag_in ? DW'(len) : '0;
                    if (nz_hit) begin
                        sum_next = sum_reg + SUMW'(len);
                        cnt_next = cnt_reg + CNTW'(1);
                    end
                    if (col_reg == nl_reg) begin
                        col_next = '0;
                        row_next = row_reg + NW'(1);
                    end else begin
                        col_next = col_reg + NW'(1);
                    end
                    if (last_pos) begin
                        row_next = '0;
                        if (cnt_reg == '0 && !nz_hit) begin
                            m_valid_next  = 1'b1;
                            m_mean_next   = '0;
                            m_noedge_next = 1'b1;
                            sum_next      = '0;
                            cnt_next      = '0;
                        end else begin
                            state_next = ST_DIVA_GO;
                        end
                    end
                end
            end
            ST_DIVA_GO: begin
                dv_rem_next = '0;
                dv_quo_next = DVD_W'(sum_reg);
                dv_den_next = cnt_reg;
                dv_cnt_next = '0;
                state_next  = ST_DIVA;
            end
            ST_DIVA, ST_DIVB: begin
                dv_rem_next = dv_ge ? (dv_sh - {1'b0, dv_den_reg}) : dv_sh;
                dv_quo_next = {dv_quo_reg[DVD_W-2:0], dv_ge};
                dv_cnt_next = dv_cnt_reg + DCW'(1);
                if (dv_cnt_reg == DCW'(DVD_W - 1)) begin
                    state_next = (state_reg == ST_DIVA) ? ST_SCALE : ST_OUT;
                end
            end
            ST_SCALE: begin
                dmax_next  = DMW'(n_reg) * DMW'(dv_quo_reg[EL-1:0]);
                k_next     = '0;
                i_next     = '0;
                state_next = ST_HEAD;
            end
            ST_HEAD: begin
                ra         = {i_reg, k_reg};
                state_next = ST_LATCH;
            end
            ST_LATCH, ST_DRAIN: begin
                dik_next = rd_a_reg;
                if (state_reg == ST_LATCH && ((i_reg == k_reg) || (rd_a_reg != '0))) begin
                    j_next     = '0;
                    state_next = ST_ROW;
                end else if (i_reg == nl_reg) begin
                    // Row sweep for this pivot is done; move to the next pivot or cap.
                    i_next = '0;
                    if (k_reg == nl_reg) begin
                        j_next     = '0;
                        state_next = ST_CAP;
                    end else begin
                        k_next     = k_reg + NW'(1);
                        state_next = ST_HEAD;
                    end
                end else begin
                    i_next     = i_reg + NW'(1);
                    state_next = ST_HEAD;
                end
            end
            ST_ROW: begin
                ra         = {k_reg, j_reg};
                rb         = {i_reg, j_reg};
                fw_pv_next = 1'b1;
                pj_next    = j_reg;
                if (j_reg == nl_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    j_next = j_reg + NW'(1);
                end
            end
            ST_CAP: begin
                ra          = {i_reg, j_reg};
                cap_pv_next = 1'b1;
                pdiag_next  = (i_reg == j_reg);
                if (j_reg == nl_reg) begin
                    j_next = '0;
                    if (i_reg == nl_reg) begin
                        state_next = ST_CAP_DRAIN;
                    end else begin
                        i_next = i_reg + NW'(1);
                    end
                end else begin
                    j_next = j_reg + NW'(1);
                end
            end
            ST_CAP_DRAIN: begin
                state_next = ST_DIVB_GO;
            end
            ST_DIVB_GO: begin
                dv_rem_next = '0;
                dv_quo_next = csum_reg;
                dv_den_next = DVS_W'(n_reg) * DVS_W'(nl_reg);
                dv_cnt_next = '0;
                state_next  = ST_DIVB;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_mean_next   = quo_x[ccpl_pkg::MEAN_W-1:0];
                    m_noedge_next = 1'b0;
                    row_next      = '0;
                    col_next      = '0;
                    sum_next      = '0;
                    cnt_next      = '0;
                    csum_next     = '0;
                    state_next    = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_a_reg <= mem[ra];
        rd_b_reg <= mem[rb];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            n_reg       <= NCW'(RST_N);
            nl_reg      <= NW'(RST_N - 1);
            row_reg     <= '0;
            col_reg     <= '0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            csum_reg    <= '0;
            fw_pv_reg   <= 1'b0;
            cap_pv_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            nl_reg      <= nl_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
            csum_reg    <= csum_next;
            fw_pv_reg   <= fw_pv_next;
            cap_pv_reg  <= cap_pv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        pj_reg       <= pj_next;
        pdiag_reg    <= pdiag_next;
        dik_reg      <= dik_next;
        dmax_reg     <= dmax_next;
        dv_rem_reg   <= dv_rem_next;
        dv_quo_reg   <= dv_quo_next;
        dv_den_reg   <= dv_den_next;
        dv_cnt_reg   <= dv_cnt_next;
        m_mean_reg   <= m_mean_next;
        m_noedge_reg <= m_noedge_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = ccpl_pkg::TDATA_W'(m_mean_reg);
    assign m_tuser  = m_noedge_reg;

    // A no-edge result always carries a zero mean.
    a_noedge_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_noedge_reg |-> m_mean_reg == '0)
        else $error("no_edges result with nonzero mean");

    // A solved mean never exceeds the cap it was computed against.
    a_mean_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_noedge_reg |-> 64'(m_mean_reg) <= 64'(dmax_reg))
        else $error("mean above distance cap");

    // A new result comes only from the output state or from a last item without edges.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT) || $past(s_accept && last_pos))
        else $error("result item without a source");

    // The relaxation pipeline only runs during the shortest-path sweep.
    a_fw_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        fw_pv_reg |-> state_reg == ST_ROW || state_reg == ST_DRAIN)
        else $error("relaxation outside the sweep");

endmodule
